/* rtl/plil_pkg.sv */
// Shared types and constants for the pump and light level interlock.
// No dependencies; the front, queue, back, top and bench import this package.
package plil_pkg;

    localparam int CFG_DW = 32;
    localparam int CFG_AW = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] PUMP_OFF_NIGHT    = 32'd3600000;
    localparam logic [31:0] PUMP_OFF_YOUNG    = 32'd900000;
    localparam int          LIGHT_ON_YOUNG_H  = 6;
    localparam int          LIGHT_ON_MATURE_H = 6;
    localparam int          LIGHT_OFF_HOUR    = 20;
    localparam int          ZONE_OFFSET_MIN   = 60;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    localparam logic [31:0] ZONE_SHIFT_S = 32'(ZONE_OFFSET_MIN * SECS_PER_MIN);

    // 86400 = 2^7 * 675; quotient by 675 via rounded-up reciprocal
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = SECS_PER_DAY / (1 << DAY_SHIFT);
    localparam int Y_W       = 32 - DAY_SHIFT;
    localparam int RECIP_K   = Y_W + $clog2(DAY_ODD);
    localparam int RECIP_W   = RECIP_K - $clog2(DAY_ODD) + 1;
    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'(((64'd1 << RECIP_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
    localparam int PROD_W    = Y_W + RECIP_W;
    localparam int QUOT_W    = 16;
    localparam int SOD_W     = 17;

    localparam logic [SOD_W-1:0] YOUNG_ON_S  = SOD_W'(LIGHT_ON_YOUNG_H * SECS_PER_HOUR);
    localparam logic [SOD_W-1:0] MATURE_ON_S = SOD_W'(LIGHT_ON_MATURE_H * SECS_PER_HOUR);
    localparam logic [SOD_W-1:0] LIGHT_OFF_S = SOD_W'(LIGHT_OFF_HOUR * SECS_PER_HOUR);

    typedef enum logic [1:0] {
        LV_NORMAL    = 2'd0,
        LV_PENDING   = 2'd1,
        LV_SETTLING  = 2'd2,
        LV_CONFIRMED = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        RS_BOOT      = 3'd0,
        RS_SCHEDULE  = 3'd1,
        RS_SETTLING  = 3'd2,
        RS_LEVEL_LOW = 3'd3,
        RS_OVERRIDE  = 3'd4
    } reason_t;

    typedef enum logic [1:0] {
        OVR_AUTO      = 2'd0,
        OVR_FORCE_ON  = 2'd1,
        OVR_FORCE_OFF = 2'd2
    } override_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_OVERRIDE       = 3'd0,
        CFG_ESTABLISHMENT  = 3'd1,
        CFG_LOW_DEBOUNCE   = 3'd2,
        CFG_SETTLE_WAIT    = 3'd3,
        CFG_SETTLE_INTERVAL = 3'd4,
        CFG_INHIBIT_AFTER  = 3'd5,
        CFG_PUMP_ON        = 3'd6,
        CFG_PUMP_OFF_DAY   = 3'd7
    } cfg_idx_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [31:0] now_ms;
        logic        clock_known;
        logic        day_young;
        logic        day_mature;
        logic        probe_neg;
        logic        probe_low;
    } task_t;

endpackage

/* rtl/plil_in_if.sv */
// Service item channel: valid/ready handshake with the input fields.
// Depends on nothing.
interface plil_in_if;
    logic              valid;
    logic              ready;
    logic [31:0]       now_ms;
    logic [31:0]       epoch_s;
    logic signed [6:0] probe_points;

    modport source (output valid, output now_ms, output epoch_s, output probe_points,
                    input ready);
    modport sink   (input valid, input now_ms, input epoch_s, input probe_points,
                    output ready);
endinterface

/* rtl/plil_out_if.sv */
// Result channel: valid/ready handshake with the result fields.
// Depends on nothing.
interface plil_out_if;
    logic       valid;
    logic       ready;
    logic       pump_on;
    logic       light_on;
    logic [2:0] pump_reason;
    logic [1:0] level_status;
    logic       changed;

    modport source (output valid, output pump_on, output light_on, output pump_reason,
                    output level_status, output changed, input ready);
    modport sink   (input valid, input pump_on, input light_on, input pump_reason,
                    input level_status, input changed, output ready);
endinterface

/* rtl/plil_front.sv */
// Front end: takes service items, works out local time of day and classifies them.
// Depends on plil_pkg and plil_in_if.
module plil_front
    import plil_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plil_in_if.sink     item,
    input  logic        push_ready,
    output logic        push_valid,
    output task_t       push_task
);

    logic              s1_valid_reg;
    logic [31:0]       sum_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [31:0]       now_reg;
    logic              known_reg;
    logic              neg_reg;
    logic              low_reg;

    logic [31:0]       sum_in;
    logic [PROD_W-1:0] prod;
    logic [32:0]       day_mult;
    logic [SOD_W-1:0]  sod;

    assign item.ready = !s1_valid_reg || push_ready;

    assign sum_in = item.epoch_s + ZONE_SHIFT_S;
    assign prod   = PROD_W'(sum_in[31:DAY_SHIFT]) * PROD_W'(DAY_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            sum_reg   <= sum_in;
            quot_reg  <= QUOT_W'(prod >> RECIP_K);
            now_reg   <= item.now_ms;
            known_reg <= (item.epoch_s != 32'd0);
            neg_reg   <= item.probe_points[6];
            low_reg   <= (item.probe_points == 7'sd0);
        end
    end

    assign day_mult = 33'(quot_reg) * 33'(SECS_PER_DAY);
    assign sod      = sum_reg[SOD_W-1:0] - day_mult[SOD_W-1:0];

    assign push_valid = s1_valid_reg;

    always_comb
    begin
        push_task.now_ms      = now_reg;
        push_task.clock_known = known_reg;
        push_task.day_young   = (sod >= YOUNG_ON_S) && (sod < LIGHT_OFF_S);
        push_task.day_mature  = (sod >= MATURE_ON_S) && (sod < LIGHT_OFF_S);
        push_task.probe_neg   = neg_reg;
        push_task.probe_low   = low_reg;
    end

endmodule

/* rtl/plil_queue.sv */
// Short queue of classified items between front and back.
// Depends on plil_pkg.
module plil_queue
    import plil_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  task_t push_task,
    output logic  push_ready,
    output logic  pop_valid,
    output task_t pop_task,
    input  logic  pop
);

    task_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_task   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

/* rtl/plil_back.sv */
// Back end: configuration registers, level interlock, pump duty cycle, light, result register.
// Depends on plil_pkg and plil_out_if.
module plil_back
    import plil_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              pop_valid,
    input  task_t             pop_task,
    output logic              pop,
    plil_out_if.source        result
);

    override_t   override_reg;
    logic        estab_reg;
    logic [31:0] debounce_reg;
    logic [31:0] settle_wait_reg;
    logic [31:0] settle_int_reg;
    logic [31:0] inhibit_reg;
    logic [31:0] pump_on_ms_reg;
    logic [31:0] pump_off_day_reg;

    level_t      level_reg,       level_next;
    logic [31:0] level_since_reg, level_since_next;
    logic [31:0] last_settle_reg, last_settle_next;
    logic        settle_ran_reg,  settle_ran_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic        phase_on_reg,    phase_on_next;
    logic        pump_reg,        pump_next;
    logic        light_reg,       light_next;
    reason_t     reason_reg,      reason_next;

    logic        out_valid_reg;
    logic        out_changed_reg;

    logic [31:0] now;
    logic        since_upd;
    logic [31:0] el_level;
    logic [31:0] el_settle;
    logic [31:0] el_level_new;
    logic [31:0] el_phase;
    logic [31:0] off_ms;

    assign now = pop_task.now_ms;
    assign pop = pop_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_reg     <= OVR_AUTO;
            estab_reg        <= 1'b1;
            debounce_reg     <= 32'd60000;
            settle_wait_reg  <= 32'd600000;
            settle_int_reg   <= 32'd3600000;
            inhibit_reg      <= 32'd86400000;
            pump_on_ms_reg   <= 32'd900000;
            pump_off_day_reg <= 32'd900000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OVERRIDE:        override_reg     <= override_t'(cfg_data[1:0]);
                CFG_ESTABLISHMENT:   estab_reg        <= cfg_data[0];
                CFG_LOW_DEBOUNCE:    debounce_reg     <= cfg_data;
                CFG_SETTLE_WAIT:     settle_wait_reg  <= cfg_data;
                CFG_SETTLE_INTERVAL: settle_int_reg   <= cfg_data;
                CFG_INHIBIT_AFTER:   inhibit_reg      <= cfg_data;
                CFG_PUMP_ON:         pump_on_ms_reg   <= cfg_data;
                CFG_PUMP_OFF_DAY:    pump_off_day_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign el_level  = now - level_since_reg;
    assign el_settle = now - last_settle_reg;

    // level interlock next state
    always_comb
    begin
        level_next       = level_reg;
        since_upd        = 1'b0;
        last_settle_next = last_settle_reg;
        settle_ran_next  = settle_ran_reg;
        if (pop_task.probe_neg)
        begin
            if (level_reg == LV_PENDING || level_reg == LV_SETTLING)
            begin
                level_next = LV_NORMAL;
                since_upd  = 1'b1;
            end
        end
        else
        begin
            case (level_reg)
                LV_NORMAL:
                begin
                    if (pop_task.probe_low)
                    begin
                        level_next = LV_PENDING;
                        since_upd  = 1'b1;
                    end
                end
                LV_PENDING:
                begin
                    if (!pop_task.probe_low)
                    begin
                        level_next = LV_NORMAL;
                        since_upd  = 1'b1;
                    end
                    else if (el_level >= debounce_reg
                             && (!settle_ran_reg || el_settle >= settle_int_reg))
                    begin
                        level_next       = LV_SETTLING;
                        since_upd        = 1'b1;
                        last_settle_next = now;
                        settle_ran_next  = 1'b1;
                    end
                end
                LV_SETTLING:
                begin
                    if (el_level >= settle_wait_reg)
                    begin
                        level_next = pop_task.probe_low ? LV_CONFIRMED : LV_NORMAL;
                        since_upd  = 1'b1;
                    end
                end
                default:
                begin
                    if (!pop_task.probe_low)
                    begin
                        level_next = LV_NORMAL;
                        since_upd  = 1'b1;
                    end
                end
            endcase
        end
    end

    assign level_since_next = since_upd ? now : level_since_reg;
    assign el_level_new     = since_upd ? 32'd0 : el_level;
    assign el_phase         = now - phase_start_reg;

    always_comb
    begin
        if (estab_reg)
        begin
            off_ms = PUMP_OFF_YOUNG;
        end
        else if (!pop_task.clock_known || pop_task.day_mature)
        begin
            off_ms = pump_off_day_reg;
        end
        else
        begin
            off_ms = PUMP_OFF_NIGHT;
        end
    end

    // pump and light decisions
    always_comb
    begin
        phase_on_next    = phase_on_reg;
        phase_start_next = phase_start_reg;
        pump_next        = 1'b0;
        reason_next      = RS_SCHEDULE;
        if (level_next == LV_SETTLING)
        begin
            reason_next = RS_SETTLING;
        end
        else if (level_next == LV_CONFIRMED && el_level_new >= inhibit_reg)
        begin
            reason_next = RS_LEVEL_LOW;
        end
        else
        begin
            case (override_reg)
                OVR_FORCE_OFF:
                begin
                    reason_next = RS_OVERRIDE;
                end
                OVR_FORCE_ON:
                begin
                    pump_next   = 1'b1;
                    reason_next = RS_OVERRIDE;
                end
                default:
                begin
                    if (phase_on_reg)
                    begin
                        if (el_phase >= pump_on_ms_reg)
                        begin
                            phase_on_next    = 1'b0;
                            phase_start_next = now;
                        end
                    end
                    else if (el_phase >= off_ms)
                    begin
                        phase_on_next    = 1'b1;
                        phase_start_next = now;
                    end
                    pump_next = phase_on_next;
                end
            endcase
        end
        light_next = pop_task.clock_known
                     && (estab_reg ? pop_task.day_young : pop_task.day_mature);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= LV_NORMAL;
            level_since_reg <= '0;
            last_settle_reg <= '0;
            settle_ran_reg  <= 1'b0;
            phase_start_reg <= '0;
            phase_on_reg    <= 1'b0;
            pump_reg        <= 1'b0;
            light_reg       <= 1'b0;
            reason_reg      <= RS_BOOT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= pop || (out_valid_reg && !result.ready);
            if (pop)
            begin
                level_reg       <= level_next;
                level_since_reg <= level_since_next;
                last_settle_reg <= last_settle_next;
                settle_ran_reg  <= settle_ran_next;
                phase_start_reg <= phase_start_next;
                phase_on_reg    <= phase_on_next;
                pump_reg        <= pump_next;
                light_reg       <= light_next;
                reason_reg      <= reason_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_changed_reg <= (pump_next != pump_reg) || (light_next != light_reg)
                               || (reason_next != reason_reg);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pump_on      = pump_reg;
    assign result.light_on     = light_reg;
    assign result.pump_reason  = 3'(reason_reg);
    assign result.level_status = 2'(level_reg);
    assign result.changed      = out_changed_reg;

endmodule

/* rtl/pump_light_level_interlock.sv */
// Top level of the pump and light level interlock.
// Depends on plil_pkg, plil_in_if, plil_out_if, plil_front, plil_queue, plil_back.
//
//  port     | dir  | transfer on         | carries
//  item     | in   | item.valid & ready  | now_ms, epoch_s, probe_points
//  result   | out  | result.valid & ready| pump_on, light_on, pump_reason, level_status, changed
//  cfg_*    | in   | cfg_wr_en           | register index and 32-bit data
//
// One item per cycle while result.ready holds; from transfer in to result valid an item
// passes the front register for the time-of-day product, a queue slot and the result register.
// The back updates all interlock state once for each item it takes.
// Asynchronous reset returns control state to defaults at once; data registers are not reset.
// A stalled result holds; six items are taken (result register, four queue slots,
// front register) before item.ready drops.
module pump_light_level_interlock
    import plil_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    plil_in_if.sink           item,
    plil_out_if.source        result,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic  push_valid;
    logic  push_ready;
    task_t push_task;
    logic  pop_valid;
    logic  pop;
    task_t pop_task;

    plil_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_task  (push_task)
    );

    plil_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_task  (push_task),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_task   (pop_task),
        .pop        (pop)
    );

    plil_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_task  (pop_task),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* tb/tb.sv */
// Self-checking bench for pump_light_level_interlock: a directed table, then random phases
// with idling, receiver hold-off and register changes, checked by a predictor or by fixed rows.
// Depends on plil_pkg, plil_in_if, plil_out_if and the block's RTL.
module tb
    import plil_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] NIGHT_OFF_MS = 32'd3600000;
    localparam logic [31:0] YOUNG_OFF_MS = 32'd900000;
    localparam int          YOUNG_ON_H   = 6;
    localparam int          MATURE_ON_H  = 6;
    localparam int          DARK_H       = 20;
    localparam logic [31:0] ZONE_S       = 32'd3600;
    localparam logic [31:0] DAY_S        = 32'd86400;

    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int PRESSURE_PH = 4;
    localparam int LIMIT       = 200000;

    // idle percentages and register style per random phase
    localparam int PH_TX[N_PHASES]    = '{0, 80, 0, 13, 0, 13};
    localparam int PH_RX[N_PHASES]    = '{0, 0, 80, 13, 0, 13};
    localparam int PH_STYLE[N_PHASES] = '{0, 1, 2, 3, 3, 0};

    typedef struct packed {
        logic    pump;
        logic    light;
        reason_t reason;
        level_t  level;
        logic    chg;
    } tower_out_t;

    typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_idx_t          reg_id;
        logic [31:0]       wdata;
        logic [31:0]       now_ms;
        logic [31:0]       epoch_s;
        logic signed [6:0] probe;
        bit                fixed;
        tower_out_t        want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    plil_in_if  svc_in();
    plil_out_if svc_out();

    pump_light_level_interlock uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (svc_in),
        .result    (svc_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor registers
    logic [1:0]  ovr;
    logic        young;
    logic [31:0] debounce_ms;
    logic [31:0] settle_ms;
    logic [31:0] chk_gap_ms;
    logic [31:0] inhibit_ms;
    logic [31:0] on_ms;
    logic [31:0] off_day_ms;

    // predictor state
    level_t      lvl;
    logic [31:0] lvl_since;
    logic [31:0] last_chk;
    logic        chk_ran;
    logic [31:0] phase_t0;
    logic        phase_is_on;
    logic        pump_q;
    logic        light_q;
    reason_t     reason_q;

    tower_out_t  tower_due[$];
    tower_out_t  due_head;
    plan_row_t   plan[$];

    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_cycles = 0;
    int          cycle_cnt = 0;

    logic [31:0] t_now;
    logic [31:0] t_epoch;
    int          run_left = 0;
    int          run_kind;
    logic signed [6:0] run_level;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void tower_reset();
        ovr         = OVR_AUTO;
        young       = 1'b1;
        debounce_ms = 32'd60000;
        settle_ms   = 32'd600000;
        chk_gap_ms  = 32'd3600000;
        inhibit_ms  = 32'd86400000;
        on_ms       = 32'd900000;
        off_day_ms  = 32'd900000;
        lvl         = LV_NORMAL;
        lvl_since   = '0;
        last_chk    = '0;
        chk_ran     = 1'b0;
        phase_t0    = '0;
        phase_is_on = 1'b0;
        pump_q      = 1'b0;
        light_q     = 1'b0;
        reason_q    = RS_BOOT;
    endfunction

    function automatic logic in_light_window(input logic [31:0] epoch, input int on_h);
        logic [31:0] sod;
        sod = (epoch + ZONE_S) % DAY_S;
        return (epoch != 32'd0) && (sod >= 32'(on_h * 3600)) && (sod < 32'(DARK_H * 3600));
    endfunction

    function automatic tower_out_t tower_step(input logic [31:0] now, input logic [31:0] epoch,
                                              input logic signed [6:0] probe);
        tower_out_t  o;
        logic        was_pump;
        logic        was_light;
        reason_t     was_reason;
        logic        low;
        logic [31:0] off_ms;
        was_pump   = pump_q;
        was_light  = light_q;
        was_reason = reason_q;
        low        = (probe == 7'sd0);

        if (probe[6])
        begin
            if (lvl == LV_PENDING || lvl == LV_SETTLING)
            begin
                lvl       = LV_NORMAL;
                lvl_since = now;
            end
        end
        else
        begin
            case (lvl)
                LV_NORMAL:
                    if (low)
                    begin
                        lvl       = LV_PENDING;
                        lvl_since = now;
                    end
                LV_PENDING:
                    if (!low)
                    begin
                        lvl       = LV_NORMAL;
                        lvl_since = now;
                    end
                    else if (now - lvl_since >= debounce_ms)
                    begin
                        if (!chk_ran || now - last_chk >= chk_gap_ms)
                        begin
                            lvl       = LV_SETTLING;
                            lvl_since = now;
                            last_chk  = now;
                            chk_ran   = 1'b1;
                        end
                    end
                LV_SETTLING:
                    if (now - lvl_since >= settle_ms)
                    begin
                        lvl       = low ? LV_CONFIRMED : LV_NORMAL;
                        lvl_since = now;
                    end
                default:
                    if (!low)
                    begin
                        lvl       = LV_NORMAL;
                        lvl_since = now;
                    end
            endcase
        end

        if (lvl == LV_SETTLING)
        begin
            pump_q   = 1'b0;
            reason_q = RS_SETTLING;
        end
        else if (lvl == LV_CONFIRMED && now - lvl_since >= inhibit_ms)
        begin
            pump_q   = 1'b0;
            reason_q = RS_LEVEL_LOW;
        end
        else if (ovr == OVR_FORCE_OFF)
        begin
            pump_q   = 1'b0;
            reason_q = RS_OVERRIDE;
        end
        else if (ovr == OVR_FORCE_ON)
        begin
            pump_q   = 1'b1;
            reason_q = RS_OVERRIDE;
        end
        else
        begin
            if (young)
                off_ms = YOUNG_OFF_MS;
            else if (epoch == 32'd0)
                off_ms = off_day_ms;
            else
                off_ms = in_light_window(epoch, MATURE_ON_H) ? off_day_ms : NIGHT_OFF_MS;
            if (phase_is_on)
            begin
                if (now - phase_t0 >= on_ms)
                begin
                    phase_is_on = 1'b0;
                    phase_t0    = now;
                end
            end
            else if (now - phase_t0 >= off_ms)
            begin
                phase_is_on = 1'b1;
                phase_t0    = now;
            end
            pump_q   = phase_is_on;
            reason_q = RS_SCHEDULE;
        end

        light_q = in_light_window(epoch, young ? YOUNG_ON_H : MATURE_ON_H);

        o.pump   = pump_q;
        o.light  = light_q;
        o.reason = reason_q;
        o.level  = lvl;
        o.chg    = (was_pump != pump_q) || (was_light != light_q) || (was_reason != reason_q);
        return o;
    endfunction

    function automatic void plan_item(input logic [31:0] t, input logic [31:0] e,
                                      input logic signed [6:0] p);
        plan_row_t row;
        row         = '{kind: ROW_ITEM, reg_id: CFG_OVERRIDE, want: '0, default: '0};
        row.kind    = ROW_ITEM;
        row.now_ms  = t;
        row.epoch_s = e;
        row.probe   = p;
        plan.push_back(row);
    endfunction

    function automatic void plan_check(input logic [31:0] t, input logic [31:0] e,
                                       input logic signed [6:0] p, input tower_out_t want);
        plan_row_t row;
        row         = '{kind: ROW_ITEM, reg_id: CFG_OVERRIDE, want: '0, default: '0};
        row.kind    = ROW_ITEM;
        row.now_ms  = t;
        row.epoch_s = e;
        row.probe   = p;
        row.fixed   = 1'b1;
        row.want    = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input cfg_idx_t idx, input logic [31:0] v);
        plan_row_t row;
        row        = '{kind: ROW_WRITE, reg_id: CFG_OVERRIDE, want: '0, default: '0};
        row.kind   = ROW_WRITE;
        row.reg_id = idx;
        row.wdata  = v;
        plan.push_back(row);
    endfunction

    function automatic logic signed [6:0] next_probe();
        if (run_left == 0)
        begin
            run_kind  = $urandom_range(0, 9);
            run_left  = $urandom_range(1, 12);
            run_level = 7'($urandom_range(1, 63));
        end
        run_left--;
        if (run_kind < 5)
            return 7'sd0;
        if (run_kind < 8)
            return run_level;
        if (run_kind == 8)
            return -7'sd1;
        return 7'($urandom);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            CFG_OVERRIDE:        ovr         = v[1:0];
            CFG_ESTABLISHMENT:   young       = v[0];
            CFG_LOW_DEBOUNCE:    debounce_ms = v;
            CFG_SETTLE_WAIT:     settle_ms   = v;
            CFG_SETTLE_INTERVAL: chk_gap_ms  = v;
            CFG_INHIBIT_AFTER:   inhibit_ms  = v;
            CFG_PUMP_ON:         on_ms       = v;
            CFG_PUMP_OFF_DAY:    off_day_ms  = v;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // style 0 short spans, 1 all zero, 2 all at the top of range, 3 mixed
    task automatic load_settings(input int style);
        logic [31:0] v;
        for (int k = 0; k < 8; k++)
        begin
            if (k < 2)
                v = (style == 1) ? 32'd0 :
                    (style == 2) ? ((k == 0) ? 32'(OVR_FORCE_OFF) : 32'd1) : $urandom;
            else if (style == 1)
                v = 32'd0;
            else if (style == 2)
                v = 32'hFFFF_FFFF;
            else if (style == 3 && $urandom_range(0, 3) == 0)
                v = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            else
                v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2500);
            write_reg(cfg_idx_t'(k), v);
        end
        end_writes();
    endtask

    task automatic offer(input logic [31:0] t, input logic [31:0] e, input logic signed [6:0] p,
                         input bit fixed, input tower_out_t want);
        tower_out_t pred;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            svc_in.valid <= 1'b0;
            @(posedge clk);
        end
        svc_in.valid        <= 1'b1;
        svc_in.now_ms       <= t;
        svc_in.epoch_s      <= e;
        svc_in.probe_points <= p;
        @(posedge clk);
        while (!svc_in.ready)
            @(posedge clk);
        pred = tower_step(t, e, p);
        tower_due.push_back(fixed ? want : pred);
    endtask

    task automatic drain_results();
        svc_in.valid <= 1'b0;
        while (tower_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            svc_out.ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            svc_out.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && svc_out.valid && svc_out.ready)
        begin
            if (tower_due.size() == 0)
            begin
                report("unexpected transfer", 32'd0, 32'd0);
            end
            else
            begin
                due_head = tower_due.pop_front();
                if (svc_out.pump_on !== due_head.pump)
                    report("pump_on", 32'(svc_out.pump_on), 32'(due_head.pump));
                if (svc_out.light_on !== due_head.light)
                    report("light_on", 32'(svc_out.light_on), 32'(due_head.light));
                if (svc_out.pump_reason !== due_head.reason)
                    report("pump_reason", 32'(svc_out.pump_reason), 32'(due_head.reason));
                if (svc_out.level_status !== due_head.level)
                    report("level_status", 32'(svc_out.level_status), 32'(due_head.level));
                if (svc_out.changed !== due_head.chg)
                    report("changed", 32'(svc_out.changed), 32'(due_head.chg));
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0]       e;
        logic signed [6:0] p;
        int                r;

        rst_n               = 1'b0;
        svc_in.valid        = 1'b0;
        svc_in.now_ms       = '0;
        svc_in.epoch_s      = '0;
        svc_in.probe_points = '0;
        svc_out.ready       = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = CFG_OVERRIDE;
        cfg_data            = '0;
        tower_reset();

        // reset defaults: young schedule, 60 s debounce, 10 min settle, 1 h spacing, 24 h inhibit
        plan_check(32'd0, 32'd0, 7'sd10,
                   '{pump: 1'b0, light: 1'b0, reason: RS_SCHEDULE, level: LV_NORMAL, chg: 1'b1});
        plan_check(32'd900000, 32'd0, 7'sd63,
                   '{pump: 1'b1, light: 1'b0, reason: RS_SCHEDULE, level: LV_NORMAL, chg: 1'b1});
        plan_item(32'd1000000, 32'd18000, 7'sd0);
        plan_item(32'd1060000, 32'd18000, 7'sd0);
        plan_item(32'd1660000, 32'd68399, 7'sd0);
        plan_item(32'd88060000, 32'd68400, 7'sd0);
        plan_item(32'd88060001, 32'd0, -7'sd1);
        plan_item(32'd88060002, 32'd0, 7'sd5);
        plan_item(32'd88100000, 32'd0, 7'sd0);
        plan_item(32'd88160000, 32'd0, 7'sd0);
        plan_item(32'd88760000, 32'd0, 7'sd5);
        plan_item(32'd88800000, 32'd0, 7'sd0);
        // settle check refused: too soon after the last one
        plan_item(32'd88900000, 32'd0, 7'sd0);
        plan_item(32'd88900001, 32'd0, -7'sd64);
        plan_write(CFG_OVERRIDE, 32'(OVR_FORCE_ON));
        plan_check(32'd89000000, 32'd0, 7'sd5,
                   '{pump: 1'b1, light: 1'b0, reason: RS_OVERRIDE, level: LV_NORMAL, chg: 1'b1});
        plan_write(CFG_OVERRIDE, 32'(OVR_FORCE_OFF));
        plan_check(32'd89000100, 32'd0, 7'sd5,
                   '{pump: 1'b0, light: 1'b0, reason: RS_OVERRIDE, level: LV_NORMAL, chg: 1'b1});
        // unused override code behaves as automatic
        plan_write(CFG_OVERRIDE, 32'd3);
        plan_item(32'd89500000, 32'd0, 7'sd5);
        plan_write(CFG_OVERRIDE, 32'(OVR_AUTO));
        plan_write(CFG_ESTABLISHMENT, 32'd0);
        plan_write(CFG_PUMP_OFF_DAY, 32'hFFFF_FFFF);
        plan_write(CFG_PUMP_ON, 32'd0);
        plan_item(32'd89600000, 32'd50400, 7'sd9);
        plan_item(32'd92000000, 32'd79200, 7'sd9);
        plan_item(32'd93200000, 32'd79200, 7'sd9);
        plan_item(32'd93200001, 32'd0, 7'sd9);
        plan_item(32'hFFFF_FFFF, 32'd0, 7'sd9);
        plan_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'sd63);
        plan_item(32'd5, 32'hFFFF_F000, 7'sd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (i == 0 || plan[i-1].kind != ROW_WRITE)
                    drain_results();
                write_reg(plan[i].reg_id, plan[i].wdata);
                if (i == plan.size() - 1 || plan[i+1].kind != ROW_WRITE)
                    end_writes();
            end
            else
            begin
                offer(plan[i].now_ms, plan[i].epoch_s, plan[i].probe, plan[i].fixed, plan[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_results();
            load_settings(PH_STYLE[ph]);
            tx_idle_pct  = PH_TX[ph];
            rx_stall_pct = PH_RX[ph];
            t_now        = (ph == 0) ? 32'hFFFF_C000 : $urandom;
            t_epoch      = $urandom;
            if (ph == PRESSURE_PH)
            begin
                @(negedge clk);
                hold_cycles = 150;
                @(posedge clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == PRESSURE_PH && n == PHASE_ITEMS / 2)
                    drain_results();
                r = $urandom_range(0, 99);
                if (r < 80)
                    t_now += $urandom_range(0, 1200);
                else if (r < 95)
                    t_now += $urandom_range(0, 40000);
                else
                    t_now += $urandom;
                t_epoch += $urandom_range(0, 3000);
                r = $urandom_range(0, 99);
                e = (r < 8) ? 32'd0 : (r < 12) ? $urandom : t_epoch;
                p = next_probe();
                offer(t_now, e, p, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
